// ----- rtl/core/afa_pkg.sv -----
// Shared types, register indexes and result codes of the area frame allocator.
package afa_pkg;

    localparam int FRAME_W   = 52;
    localparam int ADDR_W    = 64;
    localparam int NUM_W     = 5;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_AREAS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOOT_END     = 3'd4;

    // operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ALLOC  = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_LOADED = 2'd2;

    // excluded frame ranges, bounds inclusive
    typedef struct packed {
        logic [FRAME_W-1:0] kern_first;
        logic [FRAME_W-1:0] kern_last;
        logic [FRAME_W-1:0] boot_first;
        logic [FRAME_W-1:0] boot_last;
    } t_excl;

endpackage

// ----- rtl/core/afa_table.sv -----
// Memory area table: one write port, one registered read port.
module afa_table #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [IDX_W-1:0]           i_wr_addr,
    input  logic [afa_pkg::ADDR_W-1:0] i_wr_base,
    input  logic [afa_pkg::ADDR_W-1:0] i_wr_length,
    input  logic [IDX_W-1:0]           i_rd_addr,
    output logic [afa_pkg::ADDR_W-1:0] o_rd_base,
    output logic [afa_pkg::ADDR_W-1:0] o_rd_length
);

    logic [2*afa_pkg::ADDR_W-1:0] r_mem [DEPTH];
    logic [2*afa_pkg::ADDR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_base, i_wr_length};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_base   = r_rd_data[2*afa_pkg::ADDR_W-1:afa_pkg::ADDR_W];
    assign o_rd_length = r_rd_data[afa_pkg::ADDR_W-1:0];

endmodule

// ----- rtl/core/afa_seq.sv -----
// Allocation sequencer: table scans, area end check, range skips and result register.
module afa_seq #(
    parameter int MAX_AREAS  = 16,
    parameter int PAGE_BYTES = 4096,
    parameter int CW         = 5,
    parameter int IDX_W      = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [3:0]                  i_area_slot,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [afa_pkg::FRAME_W-1:0] o_frame_number,
    // configuration view
    input  logic [CW-1:0]               i_count,
    input  afa_pkg::t_excl              i_excl,
    // table access
    output logic                        o_wr_en,
    output logic [IDX_W-1:0]            o_wr_addr,
    output logic [IDX_W-1:0]            o_rd_addr,
    input  logic [afa_pkg::ADDR_W-1:0]  i_rd_base,
    input  logic [afa_pkg::ADDR_W-1:0]  i_rd_length
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int AW         = afa_pkg::ADDR_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_EV  = 3'd2;
    localparam logic [2:0] S_PICK     = 3'd3;
    localparam logic [2:0] S_CHECK    = 3'd4;
    localparam logic [2:0] S_END_CALC = 3'd5;
    localparam logic [2:0] S_END_CMP  = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [CW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_cur, n_cur;
    logic [CW-1:0]               r_pick, n_pick;
    logic                        r_have, n_have;
    logic                        r_first, n_first;
    logic                        r_chosen, n_chosen;
    logic [AW-1:0]               r_next, n_next;
    logic [AW-1:0]               r_pick_base, n_pick_base;
    logic [AW:0]                 r_end, n_end;
    logic [1:0]                  r_pend_status, n_pend_status;
    logic [afa_pkg::FRAME_W-1:0] r_pend_frame, n_pend_frame;
    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_out_status, n_out_status;
    logic [afa_pkg::FRAME_W-1:0] r_out_frame, n_out_frame;

    logic [AW:0]   end_shift;
    logic [AW-1:0] first_frame;
    logic [CW-1:0] idx_inc;
    logic          in_xfer;
    logic          qualifies;
    logic          above_end;
    logic          below_pick;
    logic          in_kernel;
    logic          in_boot;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign end_shift   = r_end >> PAGE_SHIFT;
    assign first_frame = r_pick_base >> PAGE_SHIFT;
    assign idx_inc     = r_idx + CW'(1);
    assign qualifies   = i_rd_length >= AW'(PAGE_BYTES);
    assign above_end   = i_rd_base >= r_end[AW-1:0];
    assign below_pick  = !r_have || (i_rd_base < r_pick_base);
    assign in_kernel   = (r_next >= AW'(i_excl.kern_first)) &&
                         (r_next <= AW'(i_excl.kern_last));
    assign in_boot     = (r_next >= AW'(i_excl.boot_first)) &&
                         (r_next <= AW'(i_excl.boot_last));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_wr_en     = in_xfer && (i_operation == afa_pkg::OP_LOAD) &&
                         (int'(i_area_slot) < MAX_AREAS);
    assign o_wr_addr   = IDX_W'(i_area_slot);
    assign o_rd_addr   = (r_state == S_CHECK) ? r_cur[IDX_W-1:0] : r_idx[IDX_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_cur         = r_cur;
        n_pick        = r_pick;
        n_have        = r_have;
        n_first       = r_first;
        n_chosen      = r_chosen;
        n_next        = r_next;
        n_pick_base   = r_pick_base;
        n_end         = r_end;
        n_pend_status = r_pend_status;
        n_pend_frame  = r_pend_frame;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_frame   = r_out_frame;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_operation == afa_pkg::OP_LOAD) begin
                        n_cur         = '0;
                        n_next        = '0;
                        n_chosen      = 1'b0;
                        n_pend_status = afa_pkg::ST_LOADED;
                        n_pend_frame  = '0;
                        n_state       = S_RESP;
                    end else if (r_chosen) begin
                        n_state = S_CHECK;
                    end else begin
                        n_idx   = '0;
                        n_have  = 1'b0;
                        n_first = 1'b1;
                        n_state = (i_count == '0) ? S_PICK : S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (qualifies && (r_first || above_end) && below_pick) begin
                    n_pick      = r_idx;
                    n_pick_base = i_rd_base;
                    n_have      = 1'b1;
                end
                n_idx   = idx_inc;
                n_state = (idx_inc == i_count) ? S_PICK : S_SCAN_RD;
            end
            S_PICK: begin
                n_chosen = 1'b1;
                if (r_have) begin
                    n_cur = r_pick;
                    if (r_next < first_frame) begin
                        n_next = first_frame;
                    end
                end else begin
                    n_cur = i_count;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_cur >= i_count) begin
                    n_pend_status = afa_pkg::ST_EMPTY;
                    n_pend_frame  = '0;
                    n_state       = S_RESP;
                end else begin
                    n_state = S_END_CALC;
                end
            end
            S_END_CALC: begin
                // exact last byte, carry kept in the top bit; length - 1 wraps at 64 bits
                n_end   = {1'b0, i_rd_base} + {1'b0, i_rd_length - AW'(1)};
                n_state = S_END_CMP;
            end
            S_END_CMP: begin
                if (r_next > end_shift[AW-1:0]) begin
                    n_idx   = '0;
                    n_have  = 1'b0;
                    n_first = 1'b0;
                    // an area ending past the address space has no successor
                    n_state = r_end[AW] ? S_PICK : S_SCAN_RD;
                end else if (in_kernel) begin
                    n_next = AW'(i_excl.kern_last) + AW'(1);
                end else if (in_boot) begin
                    n_next = AW'(i_excl.boot_last) + AW'(1);
                end else begin
                    n_pend_status = afa_pkg::ST_ALLOC;
                    n_pend_frame  = r_next[afa_pkg::FRAME_W-1:0];
                    n_next        = r_next + AW'(1);
                    n_state       = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend_status;
                    n_out_frame  = r_pend_frame;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_next      <= '0;
            r_chosen    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_have      <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_next      <= n_next;
            r_chosen    <= n_chosen;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_have      <= n_have;
            r_first     <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick        <= n_pick;
        r_pick_base   <= n_pick_base;
        r_end         <= n_end;
        r_pend_status <= n_pend_status;
        r_pend_frame  <= n_pend_frame;
        r_out_status  <= n_out_status;
        r_out_frame   <= n_out_frame;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_frame_number = r_out_frame;

endmodule

// ----- rtl/core/area_frame_allocator.sv -----
// Area frame allocator: hands out page frames in increasing order from a table of
// memory areas (base, length), skipping the kernel and boot frame ranges. One item
// is in work at a time. A load writes its table slot, if in range, and then posts its
// result; an allocate checks the current area, computes that area's end, compares the
// next frame against it and steps past each excluded range it meets before posting
// the frame. The first allocate after a load scans the table through its single
// registered read port to choose an area; each move to the next area when the
// current one runs out scans the table again. A stalled result does not block the
// next input transfer, only the next result. The table has no reset: allocating
// from a slot that was never loaded gives undefined frame numbers. Register writes
// take effect at once and do not restart the allocator.
module area_frame_allocator #(
    parameter int MAX_AREAS  = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [3:0]                          i_area_slot,
    input  logic [afa_pkg::ADDR_W-1:0]          i_area_base,
    input  logic [afa_pkg::ADDR_W-1:0]          i_area_length,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic [afa_pkg::FRAME_W-1:0]         o_frame_number,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [afa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [afa_pkg::FRAME_W-1:0]         i_cfg_data
);

    localparam int CW    = ($clog2(MAX_AREAS + 1) > afa_pkg::NUM_W) ?
                           $clog2(MAX_AREAS + 1) : afa_pkg::NUM_W;
    localparam int IDX_W = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;

    logic [afa_pkg::NUM_W-1:0] r_num_areas;
    afa_pkg::t_excl            r_excl;
    logic [CW-1:0]             count_ext;
    logic [CW-1:0]             count;
    logic                      cfg_xfer;

    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           rd_addr;
    logic [afa_pkg::ADDR_W-1:0] rd_base;
    logic [afa_pkg::ADDR_W-1:0] rd_length;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_areas <= '0;
            r_excl      <= '0;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                afa_pkg::REG_NUM_AREAS:    r_num_areas <= i_cfg_data[afa_pkg::NUM_W-1:0];
                afa_pkg::REG_KERNEL_START: r_excl.kern_first <= i_cfg_data;
                afa_pkg::REG_KERNEL_END:   r_excl.kern_last <= i_cfg_data;
                afa_pkg::REG_BOOT_START:   r_excl.boot_first <= i_cfg_data;
                afa_pkg::REG_BOOT_END:     r_excl.boot_last <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // entries in use, capped at the table depth
    assign count_ext = CW'(r_num_areas);
    assign count     = (count_ext > CW'(MAX_AREAS)) ? CW'(MAX_AREAS) : count_ext;

    afa_table #(
        .DEPTH (MAX_AREAS),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_base   (i_area_base),
        .i_wr_length (i_area_length),
        .i_rd_addr   (rd_addr),
        .o_rd_base   (rd_base),
        .o_rd_length (rd_length)
    );

    afa_seq #(
        .MAX_AREAS  (MAX_AREAS),
        .PAGE_BYTES (PAGE_BYTES),
        .CW         (CW),
        .IDX_W      (IDX_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_area_slot    (i_area_slot),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_frame_number (o_frame_number),
        .i_count        (count),
        .i_excl         (r_excl),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_rd_addr      (rd_addr),
        .i_rd_base      (rd_base),
        .i_rd_length    (rd_length)
    );

endmodule

// ----- rtl/core/afa_checker.sv -----
// Port-level checks of the area frame allocator and their bind.
module afa_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                i_operation,
    input logic [3:0]                          i_area_slot,
    input logic [afa_pkg::ADDR_W-1:0]          i_area_base,
    input logic [afa_pkg::ADDR_W-1:0]          i_area_length,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [1:0]                          o_status,
    input logic [afa_pkg::FRAME_W-1:0]         o_frame_number,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic [afa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input logic [afa_pkg::FRAME_W-1:0]         i_cfg_data
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_frame_number))
        else $error("result changed while stalled");

    // only a granted frame carries a frame number
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != afa_pkg::ST_ALLOC) |-> o_frame_number == '0)
        else $error("nonzero frame number without allocation");

    // one item in work at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // reset empties the result register
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind area_frame_allocator afa_checker u_afa_checker (.*);
